// File: hdl/imc_pkg.sv
// Shared types, codes and constants of the IMU motion classifier.
package imc_pkg;

  localparam int SCORE_W     = 19;
  localparam int WEIGHT_W    = 8;
  localparam int WEIGHT_FRAC = 8;
  localparam int CLASS_W     = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 19;

  localparam logic [SCORE_W-1:0]  SCORE_MAX         = '1;
  localparam logic [WEIGHT_W-1:0] GYRO_WEIGHT_RESET = 8'd90;
  localparam logic [SCORE_W-1:0]  STILL_TH_RESET    = 19'd31;
  localparam logic [SCORE_W-1:0]  LOW_TH_RESET      = 19'd115;
  localparam logic [SCORE_W-1:0]  MOVE_TH_RESET     = 19'd307;

  typedef enum logic [CLASS_W-1:0] {
    MC_UNKNOWN = 3'd0,
    MC_STILL   = 3'd1,
    MC_LOW     = 3'd2,
    MC_MOVE    = 3'd3,
    MC_JOLT    = 3'd4
  } imc_class_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GYRO_WEIGHT = 2'd0,
    REG_STILL_TH    = 2'd1,
    REG_LOW_TH      = 2'd2,
    REG_MOVE_TH     = 2'd3
  } imc_reg_t;

  typedef enum logic [1:0] {
    LANE_IDLE,
    LANE_SQUARE,
    LANE_ROOT,
    LANE_DONE
  } imc_lane_state_t;

  typedef enum logic {
    CTL_IDLE,
    CTL_BUSY
  } imc_ctl_state_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] gyro_weight;
    logic [SCORE_W-1:0]  still_threshold;
    logic [SCORE_W-1:0]  low_threshold;
    logic [SCORE_W-1:0]  move_threshold;
  } imc_cfg_t;

  // The sum of three squared differences saturates at 64 bits.
  function automatic int sum_width(input int sw);
    return (2 * sw + 2 > 64) ? 64 : 2 * sw + 2;
  endfunction

endpackage

// File: hdl/imc_sample_if.sv
// Input channel carrying one IMU sample per transfer.
interface imc_sample_if #(
  parameter int SW = 17
);
  logic          valid;
  logic          ready;
  logic          sample_valid;
  logic [SW-1:0] accel_x;
  logic [SW-1:0] accel_y;
  logic [SW-1:0] accel_z;
  logic [SW-1:0] rate_x;
  logic [SW-1:0] rate_y;
  logic [SW-1:0] rate_z;

  modport source (
    output valid, sample_valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
    input  ready
  );
  modport sink (
    input  valid, sample_valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
    output ready
  );
endinterface

// File: hdl/imc_result_if.sv
// Output channel carrying one motion class and score per transfer.
interface imc_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  motion_class;
  logic [18:0] motion_score;

  modport source (output valid, motion_class, motion_score, input ready);
  modport sink (input valid, motion_class, motion_score, output ready);
endinterface

// File: hdl/imc_lane.sv
// One delta-length lane: three axis differences, squared sum and iterative square root.
module imc_lane
  import imc_pkg::*;
#(
  parameter int SW = 17
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [SW-1:0]                 cur [3],
  input  logic [SW-1:0]                 old [3],
  output logic                          done,
  output logic [sum_width(SW)/2-1:0]    root
);

  localparam int SUMW = sum_width(SW);
  localparam int RW   = SUMW / 2;
  localparam int CW   = $clog2(RW);

  imc_lane_state_t  state, state_next;
  logic [SW-1:0]    diff [3];
  logic [SW-1:0]    mag [3];
  logic [2*SW-1:0]  prod;
  logic [SUMW-1:0]  sum;
  logic [SUMW-1:0]  sum_acc;
  logic [SUMW:0]    sum_wide;
  logic [RW+1:0]    rem;
  logic [RW+1:0]    rem_sh;
  logic [RW+1:0]    trial;
  logic             fit;
  logic [CW-1:0]    cnt;
  logic             last_square;
  logic             last_root;

  always_comb begin
    logic [SW:0] dw;
    for (int i = 0; i < 3; i++) begin
      dw     = {cur[i][SW-1], cur[i]} - {old[i][SW-1], old[i]};
      mag[i] = dw[SW] ? SW'(-dw) : dw[SW-1:0];
    end
  end

  assign sum_wide = {1'b0, sum} + (SUMW+1)'(prod);
  assign sum_acc  = sum_wide[SUMW] ? '1 : sum_wide[SUMW-1:0];
  assign rem_sh   = {rem[RW-1:0], sum[SUMW-1 -: 2]};
  assign trial    = {root, 2'b01};
  assign fit      = rem_sh >= trial;

  assign last_square = cnt == CW'(3);
  assign last_root   = cnt == CW'(RW - 1);

  always_comb begin
    state_next = state;
    case (state)
      LANE_IDLE:   if (start) state_next = LANE_SQUARE;
      LANE_SQUARE: if (last_square) state_next = LANE_ROOT;
      LANE_ROOT:   if (last_root) state_next = LANE_DONE;
      LANE_DONE:   state_next = LANE_IDLE;
      default:     state_next = LANE_IDLE;
    endcase
  end

  always_comb begin
    case (state)
      LANE_DONE: done = 1'b1;
      default:   done = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LANE_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      LANE_IDLE: begin
        if (start) begin
          diff <= mag;
          sum  <= '0;
          cnt  <= '0;
        end
      end
      LANE_SQUARE: begin
        prod    <= diff[0] * diff[0];
        diff[0] <= diff[1];
        diff[1] <= diff[2];
        if (cnt != '0) begin
          sum <= sum_acc;
        end
        if (last_square) begin
          cnt  <= '0;
          rem  <= '0;
          root <= '0;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
      LANE_ROOT: begin
        sum  <= sum << 2;
        cnt  <= cnt + 1'b1;
        rem  <= fit ? rem_sh - trial : rem_sh;
        root <= {root[RW-2:0], fit};
      end
      default: begin
      end
    endcase
  end

endmodule

// File: hdl/imc_merge.sv
// Merge stage: gyro weighting, saturation, classification and the result register.
module imc_merge
  import imc_pkg::*;
#(
  parameter int RW = 18
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  logic             pair_ok,
  input  logic [RW-1:0]    a_root,
  input  logic [RW-1:0]    g_root,
  input  imc_cfg_t         cfg,
  imc_result_if.source     results,
  output logic             busy
);

  localparam int PW = RW + WEIGHT_W;
  localparam int XW = (RW + WEIGHT_W > SCORE_W) ? RW + WEIGHT_W : SCORE_W;

  logic               w_valid;
  logic               ok_hold;
  logic [RW-1:0]      a_hold;
  logic [PW-1:0]      wprod;
  logic [XW-1:0]      a_ext;
  logic [XW-1:0]      g_ext;
  logic [SCORE_W-1:0] a_sat;
  logic [SCORE_W-1:0] g_sat;
  logic [SCORE_W:0]   score_wide;
  logic [SCORE_W-1:0] score;
  imc_class_t         cls;
  logic               load;
  logic               rvalid;
  imc_class_t         rclass;
  logic [SCORE_W-1:0] rscore;

  assign a_ext      = XW'(a_hold);
  assign g_ext      = XW'(wprod[PW-1:WEIGHT_FRAC]);
  assign a_sat      = (a_ext > XW'(SCORE_MAX)) ? SCORE_MAX : a_ext[SCORE_W-1:0];
  assign g_sat      = (g_ext > XW'(SCORE_MAX)) ? SCORE_MAX : g_ext[SCORE_W-1:0];
  assign score_wide = {1'b0, a_sat} + {1'b0, g_sat};
  assign score      = score_wide[SCORE_W] ? SCORE_MAX : score_wide[SCORE_W-1:0];

  always_comb begin
    if (!ok_hold) begin
      cls = MC_UNKNOWN;
    end else if (score < cfg.still_threshold) begin
      cls = MC_STILL;
    end else if (score < cfg.low_threshold) begin
      cls = MC_LOW;
    end else if (score < cfg.move_threshold) begin
      cls = MC_MOVE;
    end else begin
      cls = MC_JOLT;
    end
  end

  assign load = w_valid && (!rvalid || results.ready);
  assign busy = w_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      w_valid <= 1'b0;
      rvalid  <= 1'b0;
    end else begin
      if (go) begin
        w_valid <= 1'b1;
      end else if (load) begin
        w_valid <= 1'b0;
      end
      if (load) begin
        rvalid <= 1'b1;
      end else if (results.ready) begin
        rvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      wprod   <= g_root * cfg.gyro_weight;
      a_hold  <= a_root;
      ok_hold <= pair_ok;
    end
    if (load) begin
      rclass <= cls;
      rscore <= ok_hold ? score : '0;
    end
  end

  assign results.valid        = rvalid;
  assign results.motion_class = rclass;
  assign results.motion_score = rscore;

endmodule

// File: hdl/imu_motion_classifier.sv
// Top level of the IMU motion classifier.
//
// Each transfer on samples carries one IMU sample: a valid flag and three signed
// accelerometer and three signed gyro axes in Q.8. The block compares it with
// the previous sample, scores the accel delta length plus the weighted gyro
// delta length, and sends one class and score per sample on results.
// The accel and gyro lanes work side by side; each squares its three axis
// differences on one multiplier and then takes an exact square root one result
// bit per cycle, so the root loop sets the rate.
// A new sample is taken only once the lanes have finished the previous one. One
// finished result may wait in the output register while the next sample is
// already being scored; a receiver that stalls longer holds samples off once
// that second result is ready.
// The registers are written through cfg_write, cfg_index and cfg_data; the user
// must write them only while the block is idle, and the block itself does not
// enforce this. Reset restores the register defaults and forgets the stored
// sample, so the first result after reset is unknown.
module imu_motion_classifier
  import imc_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 17
) (
  input  logic                  clk,
  input  logic                  rst,
  imc_sample_if.sink            samples,
  imc_result_if.source          results,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int RW = sum_width(SAMPLE_WIDTH) / 2;

  imc_ctl_state_t          state, state_next;
  imc_cfg_t                cfg;
  logic                    accept;
  logic                    prev_valid;
  logic                    pair_ok;
  logic [SAMPLE_WIDTH-1:0] prev_accel [3];
  logic [SAMPLE_WIDTH-1:0] prev_rate [3];
  logic [SAMPLE_WIDTH-1:0] cur_accel [3];
  logic [SAMPLE_WIDTH-1:0] cur_rate [3];
  logic                    a_done;
  logic                    g_done;
  logic [RW-1:0]           a_root;
  logic [RW-1:0]           g_root;
  logic                    merge_busy;

  assign cur_accel[0] = samples.accel_x;
  assign cur_accel[1] = samples.accel_y;
  assign cur_accel[2] = samples.accel_z;
  assign cur_rate[0]  = samples.rate_x;
  assign cur_rate[1]  = samples.rate_y;
  assign cur_rate[2]  = samples.rate_z;

  assign accept = samples.valid && samples.ready;

  always_comb begin
    state_next = state;
    case (state)
      CTL_IDLE: if (accept) state_next = CTL_BUSY;
      CTL_BUSY: if (a_done) state_next = CTL_IDLE;
      default:  state_next = CTL_IDLE;
    endcase
  end

  always_comb begin
    case (state)
      CTL_IDLE: samples.ready = !merge_busy;
      default:  samples.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= CTL_IDLE;
      prev_valid <= 1'b0;
      pair_ok    <= 1'b0;
      prev_accel <= '{default: '0};
      prev_rate  <= '{default: '0};
    end else begin
      state <= state_next;
      if (accept) begin
        prev_valid <= samples.sample_valid;
        pair_ok    <= samples.sample_valid && prev_valid;
        prev_accel <= cur_accel;
        prev_rate  <= cur_rate;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gyro_weight     <= GYRO_WEIGHT_RESET;
      cfg.still_threshold <= STILL_TH_RESET;
      cfg.low_threshold   <= LOW_TH_RESET;
      cfg.move_threshold  <= MOVE_TH_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_GYRO_WEIGHT: cfg.gyro_weight     <= cfg_data[WEIGHT_W-1:0];
        REG_STILL_TH:    cfg.still_threshold <= cfg_data[SCORE_W-1:0];
        REG_LOW_TH:      cfg.low_threshold   <= cfg_data[SCORE_W-1:0];
        REG_MOVE_TH:     cfg.move_threshold  <= cfg_data[SCORE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  imc_lane #(
    .SW (SAMPLE_WIDTH)
  ) u_accel_lane (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .cur   (cur_accel),
    .old   (prev_accel),
    .done  (a_done),
    .root  (a_root)
  );

  imc_lane #(
    .SW (SAMPLE_WIDTH)
  ) u_rate_lane (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .cur   (cur_rate),
    .old   (prev_rate),
    .done  (g_done),
    .root  (g_root)
  );

  imc_merge #(
    .RW (RW)
  ) u_merge (
    .clk     (clk),
    .rst     (rst),
    .go      (a_done),
    .pair_ok (pair_ok),
    .a_root  (a_root),
    .g_root  (g_root),
    .cfg     (cfg),
    .results (results),
    .busy    (merge_busy)
  );

  assert property (@(posedge clk) disable iff (rst) a_done == g_done)
    else $error("Accel and gyro lanes finished in different cycles.");

  assert property (@(posedge clk) disable iff (rst) accept |=> !samples.ready)
    else $error("A second sample was taken while one was being scored.");

  assert property (@(posedge clk) disable iff (rst)
    results.valid && results.motion_class == MC_UNKNOWN |-> results.motion_score == '0)
    else $error("An unknown result carries a nonzero score.");

  assert property (@(posedge clk) disable iff (rst)
    results.valid && results.motion_class == MC_STILL
      |-> results.motion_score < cfg.still_threshold)
    else $error("A still result has a score at or above the still threshold.");

endmodule

// File: verif/imu_motion_classifier_test.sv
// Testbench of imu_motion_classifier: a directed table, then random phases over register settings.
module imu_motion_classifier_test;
  import imc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW            = 17;
  localparam int PERIOD        = 20;
  localparam int RESET_CYCLES  = 7;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_ITEMS   = 140;
  localparam int NPHASE        = 6;
  localparam int SQUEEZE_PHASE = 2;
  localparam int QUIET_PHASE   = 4;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int NPLAN         = 20;

  localparam logic [SW-1:0] ZR = '0;
  localparam logic [SW-1:0] PM = 17'h0FFFF;
  localparam logic [SW-1:0] NM = 17'h10000;
  localparam logic [SW-1:0] N1 = '1;
  localparam logic [SW-1:0] HA = 17'h0AAAA;
  localparam logic [SW-1:0] H5 = 17'h15555;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic               ok;
    logic [0:5][SW-1:0] axis;
  } imu_sample_t;

  typedef struct packed {
    imc_class_t         cls;
    logic [SCORE_W-1:0] score;
  } motion_t;

  typedef struct packed {
    imu_sample_t        smp;
    logic               typed;
    imc_class_t         cls;
    logic [SCORE_W-1:0] score;
  } plan_row_t;

  localparam plan_row_t PLAN [NPLAN] = '{
    '{'{1'b1, '{ZR, ZR, ZR, ZR, ZR, ZR}}, 1'b1, MC_UNKNOWN, 19'd0},
    '{'{1'b1, '{ZR, ZR, ZR, ZR, ZR, ZR}}, 1'b1, MC_STILL, 19'd0},
    '{'{1'b1, '{17'd30, ZR, ZR, ZR, ZR, ZR}}, 1'b0, MC_UNKNOWN, 19'd0},
    '{'{1'b1, '{17'd30, 17'd31, ZR, ZR, ZR, ZR}}, 1'b0, MC_UNKNOWN, 19'd0},
    '{'{1'b1, '{17'd30, 17'd31, 17'd115, ZR, ZR, ZR}}, 1'b0, MC_UNKNOWN, 19'd0},
    '{'{1'b1, '{17'd30, 17'd31, 17'd115, 17'd256, ZR, ZR}}, 1'b0, MC_UNKNOWN, 19'd0},
    '{'{1'b1, '{PM, PM, PM, PM, PM, PM}}, 1'b0, MC_UNKNOWN, 19'd0},
    '{'{1'b1, '{NM, NM, NM, NM, NM, NM}}, 1'b0, MC_UNKNOWN, 19'd0},
    '{'{1'b1, '{PM, PM, PM, PM, PM, PM}}, 1'b0, MC_UNKNOWN, 19'd0},
    '{'{1'b0, '{NM, NM, NM, NM, NM, NM}}, 1'b1, MC_UNKNOWN, 19'd0},
    '{'{1'b1, '{NM, NM, NM, NM, NM, NM}}, 1'b1, MC_UNKNOWN, 19'd0},
    '{'{1'b1, '{NM, NM, NM, NM, NM, NM}}, 1'b1, MC_STILL, 19'd0},
    '{'{1'b0, '{ZR, ZR, ZR, ZR, ZR, ZR}}, 1'b1, MC_UNKNOWN, 19'd0},
    '{'{1'b0, '{ZR, ZR, ZR, ZR, ZR, ZR}}, 1'b1, MC_UNKNOWN, 19'd0},
    '{'{1'b1, '{ZR, ZR, ZR, ZR, ZR, ZR}}, 1'b1, MC_UNKNOWN, 19'd0},
    '{'{1'b1, '{N1, ZR, ZR, ZR, ZR, ZR}}, 1'b0, MC_UNKNOWN, 19'd0},
    '{'{1'b1, '{17'd1, ZR, ZR, N1, ZR, ZR}}, 1'b0, MC_UNKNOWN, 19'd0},
    '{'{1'b1, '{17'd1, ZR, ZR, N1, ZR, PM}}, 1'b0, MC_UNKNOWN, 19'd0},
    '{'{1'b1, '{HA, H5, HA, H5, HA, H5}}, 1'b0, MC_UNKNOWN, 19'd0},
    '{'{1'b1, '{H5, HA, H5, HA, H5, HA}}, 1'b0, MC_UNKNOWN, 19'd0}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  imc_sample_if #(.SW(SW)) smp_ch ();
  imc_result_if            res_ch ();

  imu_motion_classifier #(
    .SAMPLE_WIDTH(SW)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .samples   (smp_ch),
    .results   (res_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  logic [WEIGHT_W-1:0] weight   = GYRO_WEIGHT_RESET;
  logic [SCORE_W-1:0]  still_th = STILL_TH_RESET;
  logic [SCORE_W-1:0]  low_th   = LOW_TH_RESET;
  logic [SCORE_W-1:0]  move_th  = MOVE_TH_RESET;

  logic               held_ok = 1'b0;
  logic [0:5][SW-1:0] held_axis = '0;

  motion_t expected_motion [$];
  int      mismatches = 0;
  int      cycle_count = 0;
  bit      quiet = 1'b0;
  bit      squeeze_req = 1'b0;

  always #(PERIOD / 2) clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Exact floor of the length of the three-axis difference starting at axis base.
  function automatic u64_t delta_len(input logic [0:5][SW-1:0] cur, old, input int base);
    longint d;
    u64_t   sum, root, cand;
    sum  = 0;
    root = 0;
    for (int i = base; i < base + 3; i++) begin
      d   = longint'($signed(cur[i])) - longint'($signed(old[i]));
      sum += u64_t'(d * d);
    end
    for (int b = 31; b >= 0; b--) begin
      cand = root | (u64_t'(1) << b);
      if (cand * cand <= sum) root = cand;
    end
    return root;
  endfunction

  function automatic motion_t predict_motion(input imu_sample_t s);
    motion_t m;
    u64_t    a, g, gw, total;
    m.cls   = MC_UNKNOWN;
    m.score = '0;
    if (s.ok && held_ok) begin
      a  = delta_len(s.axis, held_axis, 0);
      g  = delta_len(s.axis, held_axis, 3);
      gw = (g * u64_t'(weight)) >> WEIGHT_FRAC;
      if (a > u64_t'(SCORE_MAX)) a = u64_t'(SCORE_MAX);
      if (gw > u64_t'(SCORE_MAX)) gw = u64_t'(SCORE_MAX);
      total = a + gw;
      if (total > u64_t'(SCORE_MAX)) total = u64_t'(SCORE_MAX);
      m.score = total[SCORE_W-1:0];
      if (m.score < still_th) m.cls = MC_STILL;
      else if (m.score < low_th) m.cls = MC_LOW;
      else if (m.score < move_th) m.cls = MC_MOVE;
      else m.cls = MC_JOLT;
    end
    held_ok   = s.ok;
    held_axis = s.axis;
    return m;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("%0t ns: %s", $time, what);
  endtask

  task automatic offer_sample(input imu_sample_t s, input logic typed,
                              input imc_class_t cls, input logic [SCORE_W-1:0] score);
    int      gap;
    motion_t want;
    gap = pick_gap();
    if (gap > 0) begin
      smp_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    smp_ch.valid        <= 1'b1;
    smp_ch.sample_valid <= s.ok;
    smp_ch.accel_x      <= s.axis[0];
    smp_ch.accel_y      <= s.axis[1];
    smp_ch.accel_z      <= s.axis[2];
    smp_ch.rate_x       <= s.axis[3];
    smp_ch.rate_y       <= s.axis[4];
    smp_ch.rate_z       <= s.axis[5];
    @(posedge clk);
    while (!smp_ch.ready) @(posedge clk);
    want = predict_motion(s);
    if (typed) begin
      want.cls   = cls;
      want.score = score;
    end
    expected_motion.push_back(want);
    @(negedge clk);
  endtask

  initial begin
    imu_sample_t        s;
    imu_sample_t        gen_last;
    logic [SCORE_W-1:0] reg_val [4];
    int                 pick;
    int                 span;
    int                 k;
    smp_ch.valid        <= 1'b0;
    smp_ch.sample_valid <= 1'b0;
    smp_ch.accel_x      <= '0;
    smp_ch.accel_y      <= '0;
    smp_ch.accel_z      <= '0;
    smp_ch.rate_x       <= '0;
    smp_ch.rate_y       <= '0;
    smp_ch.rate_z       <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NPLAN; i++) begin
      offer_sample(PLAN[i].smp, PLAN[i].typed, PLAN[i].cls, PLAN[i].score);
    end
    gen_last = PLAN[NPLAN-1].smp;

    for (int ph = 0; ph < NPHASE; ph++) begin
      smp_ch.valid <= 1'b0;
      while (expected_motion.size() != 0) @(negedge clk);
      repeat (SETTLE_CYCLES) @(negedge clk);
      case (ph)
        0: begin
          reg_val[REG_GYRO_WEIGHT] = 19'd255;
          reg_val[REG_STILL_TH]    = '0;
          reg_val[REG_LOW_TH]      = '0;
          reg_val[REG_MOVE_TH]     = '0;
        end
        1: begin
          reg_val[REG_GYRO_WEIGHT] = '0;
          reg_val[REG_STILL_TH]    = SCORE_MAX;
          reg_val[REG_LOW_TH]      = SCORE_MAX;
          reg_val[REG_MOVE_TH]     = SCORE_MAX;
        end
        2: begin
          reg_val[REG_GYRO_WEIGHT] = 19'd128;
          reg_val[REG_STILL_TH]    = 19'd200;
          reg_val[REG_LOW_TH]      = 19'd600;
          reg_val[REG_MOVE_TH]     = 19'd2000;
        end
        3: begin
          reg_val[REG_GYRO_WEIGHT] = SCORE_W'($urandom_range(0, 255));
          reg_val[REG_STILL_TH]    = SCORE_W'($urandom_range(0, 4000));
          reg_val[REG_LOW_TH]      = SCORE_W'($urandom_range(0, 4000));
          reg_val[REG_MOVE_TH]     = SCORE_W'($urandom_range(0, 4000));
        end
        QUIET_PHASE: begin
          reg_val[REG_GYRO_WEIGHT] = SCORE_W'(GYRO_WEIGHT_RESET);
          reg_val[REG_STILL_TH]    = STILL_TH_RESET;
          reg_val[REG_LOW_TH]      = LOW_TH_RESET;
          reg_val[REG_MOVE_TH]     = MOVE_TH_RESET;
        end
        default: begin
          reg_val[REG_GYRO_WEIGHT] = SCORE_W'($urandom_range(0, 255));
          reg_val[REG_STILL_TH]    = SCORE_W'($urandom_range(0, 500));
          reg_val[REG_LOW_TH]      = reg_val[REG_STILL_TH]
                                     + SCORE_W'($urandom_range(0, 1500));
          reg_val[REG_MOVE_TH]     = reg_val[REG_LOW_TH]
                                     + SCORE_W'($urandom_range(0, 3000));
        end
      endcase
      for (int r = 0; r < 4; r++) begin
        cfg_write <= 1'b1;
        cfg_index <= imc_reg_t'(r);
        cfg_data  <= reg_val[r];
        @(negedge clk);
      end
      cfg_write   <= 1'b0;
      weight      = reg_val[REG_GYRO_WEIGHT][WEIGHT_W-1:0];
      still_th    = reg_val[REG_STILL_TH];
      low_th      = reg_val[REG_LOW_TH];
      move_th     = reg_val[REG_MOVE_TH];
      quiet       = (ph == QUIET_PHASE);
      squeeze_req = (ph == SQUEEZE_PHASE);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        s    = gen_last;
        s.ok = 1'b1;
        if (pick < 10 || (pick >= 72 && pick < 90)) begin
          s.ok = (pick >= 10);
          for (int a = 0; a < 6; a++) s.axis[a] = SW'($urandom);
        end else if (pick < 60) begin
          // Small moves around the last sample keep scores near the thresholds.
          span = 1 << $urandom_range(0, 11);
          for (int a = 0; a < 6; a++) begin
            s.axis[a] = s.axis[a] + SW'(int'($urandom_range(0, 2 * span)) - span);
          end
        end else if (pick < 72) begin
          k         = $urandom_range(0, 5);
          s.axis[k] = s.axis[k] + SW'(int'($urandom_range(0, 64)) - 32);
        end else begin
          for (int a = 0; a < 6; a++) begin
            case ($urandom_range(0, 3))
              0:       s.axis[a] = PM;
              1:       s.axis[a] = NM;
              2:       s.axis[a] = ZR;
              default: s.axis[a] = N1;
            endcase
          end
        end
        gen_last = s;
        offer_sample(s, 1'b0, MC_UNKNOWN, '0);
      end
    end

    smp_ch.valid <= 1'b0;
    quiet = 1'b0;
    while (expected_motion.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    int len;
    res_ch.ready <= 1'b0;
    @(negedge clk);
    forever begin
      if (squeeze_req) begin
        len         = HOLD_CYCLES;
        squeeze_req = 1'b0;
      end else begin
        len = pick_gap();
      end
      if (len > 0) begin
        res_ch.ready <= 1'b0;
        repeat (len) @(negedge clk);
      end
      res_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    motion_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_motion.size() == 0) begin
        report_mismatch("result transfer with nothing expected");
      end else begin
        want = expected_motion.pop_front();
        if (res_ch.motion_class !== want.cls) begin
          report_mismatch($sformatf("motion_class %0d, expected %s",
                                    res_ch.motion_class, want.cls.name()));
        end
        if (res_ch.motion_score !== want.score) begin
          report_mismatch($sformatf("motion_score %0d, expected %0d",
                                    res_ch.motion_score, want.score));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule
